// ----- rtl/core/skewed_glyph_bit_expander_core_macros.svh -----
// Assertion macros shared by the glyph expander RTL.
// Included by the files that carry concurrent checks; no other dependencies.
`ifndef SKEWED_GLYPH_BIT_EXPANDER_CORE_MACROS_SVH
`define SKEWED_GLYPH_BIT_EXPANDER_CORE_MACROS_SVH

// Check that a condition implies another in the same cycle.
`define SGBE_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check that a condition implies another in the next cycle.
`define SGBE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/sgbe_pkg.sv -----
// Shared types and constants of the glyph bit expander.
// No dependencies; imported by every module of the block.
package sgbe_pkg;

  // Sizing defaults
  localparam int SGBE_MAX_ROW_BYTES = 31;
  localparam int SGBE_QUEUE_DEPTH   = 2;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_GLYPH_WIDTH  = 3'd0,
    REG_GLYPH_HEIGHT = 3'd1,
    REG_SKEW_PERIOD  = 3'd2,
    REG_CLIP_ENABLE  = 3'd3,
    REG_CLIP_LEFT    = 3'd4,
    REG_CLIP_TOP     = 3'd5,
    REG_CLIP_RIGHT   = 3'd6,
    REG_CLIP_BOTTOM  = 3'd7
  } sgbe_reg_idx_t;

  // Register reset values
  localparam logic [7:0]  RST_GLYPH_WIDTH  = 8'd8;
  localparam logic [7:0]  RST_GLYPH_HEIGHT = 8'd8;
  localparam logic [7:0]  RST_SKEW_PERIOD  = 8'd0;
  localparam logic        RST_CLIP_ENABLE  = 1'b0;
  localparam logic [15:0] RST_CLIP_LEFT    = 16'h0000;
  localparam logic [15:0] RST_CLIP_TOP     = 16'h0000;
  localparam logic [15:0] RST_CLIP_RIGHT   = 16'h7FFF;
  localparam logic [15:0] RST_CLIP_BOTTOM  = 16'h7FFF;

  // Configuration register file contents
  typedef struct packed {
    logic [7:0]         glyph_width;
    logic [7:0]         glyph_height;
    logic [7:0]         skew_period;
    logic               clip_enable;
    logic signed [15:0] clip_left;
    logic signed [15:0] clip_top;
    logic signed [15:0] clip_right;
    logic signed [15:0] clip_bottom;
  } sgbe_cfg_t;

  // One classified byte request between front and back
  typedef struct packed {
    logic signed [17:0] x;
    logic signed [16:0] y;
    logic [7:0]         bits;
    logic [31:0]        color;
    logic               done;
    logic               rejected;
  } sgbe_item_t;

endpackage

// ----- rtl/core/sgbe_front.sv -----
// Front end: tracks glyph row/byte position, skew and rejection per request.
// Depends on sgbe_pkg; feeds sgbe_queue.
module sgbe_front import sgbe_pkg::*; #(
  parameter int MAX_ROW_BYTES = SGBE_MAX_ROW_BYTES
) (
  input  logic               clk,
  input  logic               rst_n,
  input  sgbe_cfg_t          cfg,
  input  logic               push_i,
  input  logic [7:0]         glyph_byte_i,
  input  logic               first_byte_i,
  input  logic signed [15:0] origin_x_i,
  input  logic signed [15:0] origin_y_i,
  input  logic [31:0]        pen_color_i,
  output sgbe_item_t         item_o
);

  logic [7:0]  row_index_r,     row_index_nxt;
  logic [4:0]  byte_in_row_r,   byte_in_row_nxt;
  logic [16:0] row_start_x_r,   row_start_x_nxt;
  logic [16:0] current_y_r,     current_y_nxt;
  logic [8:0]  next_skew_row_r, next_skew_row_nxt;
  logic        glyph_rejected_r, glyph_rejected_nxt;
  logic [31:0] latched_color_r, latched_color_nxt;

  logic [7:0]  eff_row;
  logic [4:0]  eff_byte;
  logic [16:0] eff_rsx, skew_rsx, eff_y;
  logic [8:0]  eff_nsr, skew_nsr;
  logic        eff_rej, skew_now, reject_now;
  logic [31:0] eff_color;
  logic [8:0]  width_sum;
  logic [5:0]  bpr_raw, bpr;
  logic [7:0]  hgt;
  logic        row_end, glyph_end;

  // Rejection test against the clip window on the first byte
  always_comb begin
    reject_now = cfg.clip_enable && (
      (origin_x_i > cfg.clip_right) ||
      (origin_y_i > cfg.clip_bottom) ||
      ($signed({{2{origin_x_i[15]}}, origin_x_i}) + $signed({10'b0, cfg.glyph_width})
        < $signed({{2{cfg.clip_left[15]}}, cfg.clip_left})) ||
      ($signed({{2{origin_y_i[15]}}, origin_y_i}) + $signed({10'b0, cfg.glyph_height})
        < $signed({{2{cfg.clip_top[15]}}, cfg.clip_top})));
  end

  // Pick latched or fresh glyph state, then apply skew at a skew row start
  always_comb begin
    eff_row   = first_byte_i ? 8'd0 : row_index_r;
    eff_byte  = first_byte_i ? 5'd0 : byte_in_row_r;
    eff_rsx   = first_byte_i ? {origin_x_i[15], origin_x_i} : row_start_x_r;
    eff_y     = first_byte_i ? {origin_y_i[15], origin_y_i} : current_y_r;
    eff_nsr   = first_byte_i ? {1'b0, cfg.skew_period} : next_skew_row_r;
    eff_rej   = first_byte_i ? reject_now : glyph_rejected_r;
    eff_color = first_byte_i ? pen_color_i : latched_color_r;

    skew_now = (eff_byte == 5'd0) && (cfg.skew_period != 8'd0) && (eff_row != 8'd0) &&
               ({1'b0, eff_row} == eff_nsr);
    skew_rsx = skew_now ? eff_rsx - 17'd1 : eff_rsx;
    skew_nsr = skew_now ? eff_nsr + {1'b0, cfg.skew_period} : eff_nsr;
  end

  // Row length and glyph height limits
  always_comb begin
    width_sum = {1'b0, cfg.glyph_width} + 9'd7;
    bpr_raw   = width_sum[8:3];
    priority if (bpr_raw == 6'd0) begin
      bpr = 6'd1;
    end else if (bpr_raw > 6'(MAX_ROW_BYTES)) begin
      bpr = 6'(MAX_ROW_BYTES);
    end else begin
      bpr = bpr_raw;
    end
    hgt       = (cfg.glyph_height == 8'd0) ? 8'd1 : cfg.glyph_height;
    row_end   = ({1'b0, eff_byte} + 6'd1) >= bpr;
    glyph_end = row_end && (({1'b0, eff_row} + 9'd1) >= {1'b0, hgt});
  end

  // Advance counters past this byte
  always_comb begin
    row_start_x_nxt    = skew_rsx;
    glyph_rejected_nxt = eff_rej;
    latched_color_nxt  = eff_color;
    byte_in_row_nxt    = row_end ? 5'd0 : eff_byte + 5'd1;
    current_y_nxt      = row_end ? eff_y + 17'd1 : eff_y;
    priority if (glyph_end) begin
      row_index_nxt     = 8'd0;
      next_skew_row_nxt = {1'b0, cfg.skew_period};
    end else if (row_end) begin
      row_index_nxt     = eff_row + 8'd1;
      next_skew_row_nxt = skew_nsr;
    end else begin
      row_index_nxt     = eff_row;
      next_skew_row_nxt = skew_nsr;
    end
  end

  // Build the request handed to the queue
  always_comb begin
    item_o.x        = $signed({skew_rsx[16], skew_rsx}) + $signed({10'b0, eff_byte, 3'b000});
    item_o.y        = $signed(eff_y);
    item_o.bits     = glyph_byte_i;
    item_o.color    = eff_color;
    item_o.done     = glyph_end;
    item_o.rejected = eff_rej;
  end

  // Hold glyph state between accepted bytes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_index_r      <= '0;
      byte_in_row_r    <= '0;
      row_start_x_r    <= '0;
      current_y_r      <= '0;
      next_skew_row_r  <= '0;
      glyph_rejected_r <= 1'b0;
      latched_color_r  <= '0;
    end else if (push_i) begin
      row_index_r      <= row_index_nxt;
      byte_in_row_r    <= byte_in_row_nxt;
      row_start_x_r    <= row_start_x_nxt;
      current_y_r      <= current_y_nxt;
      next_skew_row_r  <= next_skew_row_nxt;
      glyph_rejected_r <= glyph_rejected_nxt;
      latched_color_r  <= latched_color_nxt;
    end
  end

endmodule

// ----- rtl/core/sgbe_queue.sv -----
// Short request queue between the front end and the span back end.
// Depends on sgbe_pkg and the shared assertion macros.
`include "skewed_glyph_bit_expander_core_macros.svh"
module sgbe_queue import sgbe_pkg::*; #(
  parameter int DEPTH = SGBE_QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push_i,
  input  sgbe_item_t push_item_i,
  output logic       full_o,
  input  logic       pop_i,
  output logic       empty_o,
  output sgbe_item_t head_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  sgbe_item_t        entries_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;

  assign full_o  = (count_r == CNT_W'(DEPTH));
  assign empty_o = (count_r == '0);
  assign head_o  = entries_r[rd_ptr_r];

  // Advance pointers with wrap at the last entry
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push_i) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    unique case ({push_i, pop_i})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store pushed requests
  always_ff @(posedge clk) begin
    if (push_i) begin
      entries_r[wr_ptr_r] <= push_item_i;
    end
  end

  `SGBE_ASSERT_SAME(a_cnt_bound, clk, rst_n, 1'b1, count_r <= CNT_W'(DEPTH), "queue overfilled")
  `SGBE_ASSERT_SAME(a_no_pop_empty, clk, rst_n, pop_i, !empty_o, "pop from empty queue")
  `SGBE_ASSERT_SAME(a_no_push_full, clk, rst_n, push_i, !full_o, "push into full queue")
  `SGBE_ASSERT_NEXT(a_cnt_up, clk, rst_n, push_i && !pop_i, count_r == $past(count_r) + 1'b1, "count did not rise")

endmodule

// ----- rtl/core/sgbe_back.sv -----
// Back end: clips the queued span against the window and holds the result.
// Depends on sgbe_pkg; drains sgbe_queue.
module sgbe_back import sgbe_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  sgbe_cfg_t          cfg,
  input  logic               empty_i,
  input  sgbe_item_t         head_i,
  output logic               pop_o,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [16:0] out_span_x,
  output logic signed [16:0] out_span_y,
  output logic [7:0]         out_pixel_mask,
  output logic [31:0]        out_span_color,
  output logic               out_glyph_done
);

  logic               out_valid_r;
  logic signed [16:0] span_x_r, span_y_r;
  logic [7:0]         mask_r, mask_nxt;
  logic [31:0]        color_r;
  logic               done_r;
  logic signed [17:0] cl_ext, cr_ext;
  logic signed [16:0] ct_ext, cb_ext;
  logic               row_in;
  logic signed [17:0] px [8];

  assign pop_o = !empty_i && (!out_valid_r || out_ready);

  // Mask each pixel against the clip window
  always_comb begin
    cl_ext = $signed({{2{cfg.clip_left[15]}}, cfg.clip_left});
    cr_ext = $signed({{2{cfg.clip_right[15]}}, cfg.clip_right});
    ct_ext = $signed({cfg.clip_top[15], cfg.clip_top});
    cb_ext = $signed({cfg.clip_bottom[15], cfg.clip_bottom});
    row_in = (head_i.y >= ct_ext) && (head_i.y <= cb_ext);
    for (int k = 0; k < 8; k++) begin
      px[k] = head_i.x + $signed({15'b0, 3'(k)});
      mask_nxt[7-k] = head_i.bits[7-k] && !head_i.rejected &&
                      (!cfg.clip_enable || (row_in && px[k] >= cl_ext && px[k] <= cr_ext));
    end
  end

  // Hold the result until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pop_o) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop_o) begin
      span_x_r <= head_i.x[16:0];
      span_y_r <= head_i.y;
      mask_r   <= mask_nxt;
      color_r  <= head_i.color;
      done_r   <= head_i.done;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_span_x     = span_x_r;
  assign out_span_y     = span_y_r;
  assign out_pixel_mask = mask_r;
  assign out_span_color = color_r;
  assign out_glyph_done = done_r;

endmodule

// ----- rtl/core/skewed_glyph_bit_expander_core.sv -----
// Top level of the skewed glyph bit expander: register file, front, queue, back.
// Depends on sgbe_pkg, sgbe_front, sgbe_queue and sgbe_back.
//
//   port group | direction | handshake           | payload
//   in_        | request   | in_valid/in_ready   | glyph_byte, first_byte, origin, pen_color
//   out_       | result    | out_valid/out_ready | span_x, span_y, pixel_mask, color, done
//   cfg_       | write     | cfg_write_en        | cfg_index, cfg_data
//
// One byte request per cycle sustained while out_ready stays high; each result
// is written into a queue entry and then loaded into the output register.
// Synchronous active-low reset clears the glyph counters, the queue and the
// register file to its defaults. A stalled output backs up the queue, and
// in_ready drops only once the queue is full.
module skewed_glyph_bit_expander_core import sgbe_pkg::*; #(
  parameter int MAX_ROW_BYTES = SGBE_MAX_ROW_BYTES,
  parameter int QUEUE_DEPTH   = SGBE_QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_write_en,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_glyph_byte,
  input  logic               in_first_byte,
  input  logic signed [15:0] in_origin_x,
  input  logic signed [15:0] in_origin_y,
  input  logic [31:0]        in_pen_color,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [16:0] out_span_x,
  output logic signed [16:0] out_span_y,
  output logic [7:0]         out_pixel_mask,
  output logic [31:0]        out_span_color,
  output logic               out_glyph_done
);

  sgbe_cfg_t  cfg_r;
  sgbe_item_t push_item, head_item;
  logic       push, pop, q_full, q_empty;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.glyph_width  <= RST_GLYPH_WIDTH;
      cfg_r.glyph_height <= RST_GLYPH_HEIGHT;
      cfg_r.skew_period  <= RST_SKEW_PERIOD;
      cfg_r.clip_enable  <= RST_CLIP_ENABLE;
      cfg_r.clip_left    <= RST_CLIP_LEFT;
      cfg_r.clip_top     <= RST_CLIP_TOP;
      cfg_r.clip_right   <= RST_CLIP_RIGHT;
      cfg_r.clip_bottom  <= RST_CLIP_BOTTOM;
    end else if (cfg_write_en) begin
      unique case (sgbe_reg_idx_t'(cfg_index))
        REG_GLYPH_WIDTH:  cfg_r.glyph_width  <= cfg_data[7:0];
        REG_GLYPH_HEIGHT: cfg_r.glyph_height <= cfg_data[7:0];
        REG_SKEW_PERIOD:  cfg_r.skew_period  <= cfg_data[7:0];
        REG_CLIP_ENABLE:  cfg_r.clip_enable  <= cfg_data[0];
        REG_CLIP_LEFT:    cfg_r.clip_left    <= cfg_data;
        REG_CLIP_TOP:     cfg_r.clip_top     <= cfg_data;
        REG_CLIP_RIGHT:   cfg_r.clip_right   <= cfg_data;
        REG_CLIP_BOTTOM:  cfg_r.clip_bottom  <= cfg_data;
        default:          cfg_r <= cfg_r;
      endcase
    end
  end

  // Accept a request whenever the queue has room
  assign in_ready = !q_full;
  assign push     = in_valid && in_ready;

  sgbe_front #(
    .MAX_ROW_BYTES(MAX_ROW_BYTES)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg_r),
    .push_i       (push),
    .glyph_byte_i (in_glyph_byte),
    .first_byte_i (in_first_byte),
    .origin_x_i   (in_origin_x),
    .origin_y_i   (in_origin_y),
    .pen_color_i  (in_pen_color),
    .item_o       (push_item)
  );

  sgbe_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk         (clk),
    .rst_n       (rst_n),
    .push_i      (push),
    .push_item_i (push_item),
    .full_o      (q_full),
    .pop_i       (pop),
    .empty_o     (q_empty),
    .head_o      (head_item)
  );

  sgbe_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg_r),
    .empty_i        (q_empty),
    .head_i         (head_item),
    .pop_o          (pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_span_x     (out_span_x),
    .out_span_y     (out_span_y),
    .out_pixel_mask (out_pixel_mask),
    .out_span_color (out_span_color),
    .out_glyph_done (out_glyph_done)
  );

endmodule
